### hw/rtl/frvt_pkg.sv
// frvt_pkg: shared types and constants for the frame-rate vote table
// used by frvt_ctrl, frvt_dp and frame_rate_vote_table_unit; no dependencies
`timescale 1ns / 1ps

package frvt_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int RATE_W   = 10;
  localparam int SRC_W    = 2;
  localparam int STATUS_W = 2;

  // input tdata layout
  localparam int KEY_LSB  = 0;
  localparam int RATE_LSB = KEY_LSB + KEY_W;
  localparam int FV_LSB   = RATE_LSB + RATE_W;
  localparam int IN_DATA_W = 48;

  // output tdata layout
  localparam int EXP_LSB    = 0;
  localparam int SRC_LSB    = EXP_LSB + RATE_W;
  localparam int CHG_LSB    = SRC_LSB + SRC_W;
  localparam int SYNC_LSB   = CHG_LSB + 1;
  localparam int STATUS_LSB = SYNC_LSB + RATE_W;
  localparam int OUT_USED_W = STATUS_LSB + STATUS_W;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_UPDATE    = 3'd2,
    CMD_SET_ANIM  = 3'd3,
    CMD_SET_SYNC  = 3'd4,
    CMD_WRITE_FLG = 3'd5,
    CMD_QUERY     = 3'd6
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_APPLIED  = 2'd0,
    STS_NOEFFECT = 2'd1,
    STS_FULL     = 2'd2
  } status_e_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_NONE  = 2'd0,
    SRC_TABLE = 2'd1,
    SRC_SYNC  = 2'd2,
    SRC_ANIM  = 2'd3
  } src_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_e_t;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/frame_rate_vote_table_unit.sv
// frame_rate_vote_table_unit: top level of the frame-rate vote table
// depends on frvt_pkg, frvt_ctrl and frvt_dp
`timescale 1ns / 1ps

// One command beat is taken in an idle cycle; the unit then walks every slot of the
// single-port entry memory once, waits in a drain state for the last read and then
// applies the change. The result beat sits in an output register; a new command is
// taken while it waits, and the apply step holds only if the previous result is
// still untaken. The walk through the entry memory sets the rate.
module frame_rate_vote_table_unit #(
  parameter int TABLE_ENTRIES = frvt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node_id[31:0], rate[41:32], flag_value[42]
  input  logic [frvt_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [frvt_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // expected_rate[9:0], rate_source[11:10], changed[12], display_sync_rate[22:13],
  // status[24:23]
  output logic [frvt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import frvt_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  frvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  frvt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/frvt_ctrl.sv
// frvt_ctrl: sequencer for one command (accept, table walk, apply)
// depends on frvt_pkg; drives frvt_dp through ctl_cmd_t
`timescale 1ns / 1ps

module frvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  frvt_pkg::dp_sts_t  sts,
  output frvt_pkg::ctl_cmd_t ctl
);
  import frvt_pkg::*;

  state_e_t state_r;
  state_e_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.read = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/frvt_dp.sv
// frvt_dp: entry memory, valid bits, rate registers, walk accumulators, result register
// depends on frvt_pkg; sequenced by frvt_ctrl
`timescale 1ns / 1ps

module frvt_dp #(
  parameter int TABLE_ENTRIES = frvt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  frvt_pkg::ctl_cmd_t              ctl,
  output frvt_pkg::dp_sts_t               sts,
  input  logic [frvt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [frvt_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [frvt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import frvt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // latched command
  cmd_e_t            cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [RATE_W-1:0] rate_r;
  logic              fv_r;

  // entry memory and valid bits
  logic [KEY_W+RATE_W-1:0] mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [RATE_W-1:0] anim_r;
  logic [RATE_W-1:0] sync_r;
  logic              flag_r;

  // walk
  logic [IDX_W-1:0]  idx_r;
  logic              pend_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_v_r;
  logic [KEY_W+RATE_W-1:0] rd_data_r;

  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [RATE_W-1:0] match_rate_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              any_other_r;
  logic [RATE_W-1:0] max_other_r;

  logic [KEY_W-1:0]  rd_key;
  logic [RATE_W-1:0] rd_rate;
  logic              hit;

  // result register
  logic                  out_valid_r;
  logic [OUT_USED_W-1:0] out_data_r;

  // apply decode
  logic              mem_we;
  logic [IDX_W-1:0]  wr_idx;
  logic              set_valid;
  logic              clr_valid;
  logic [RATE_W-1:0] anim_nxt;
  logic [RATE_W-1:0] sync_nxt;
  logic              flag_nxt;
  status_e_t         status_nxt;
  logic              add_applied;
  logic              upd_applied;
  logic              keep_match;
  logic [RATE_W-1:0] match_val;
  logic              t_any;
  logic [RATE_W-1:0] best;
  src_e_t            src;

  assign rd_key  = rd_data_r[KEY_W+RATE_W-1:RATE_W];
  assign rd_rate = rd_data_r[RATE_W-1:0];
  assign hit     = pend_r && rd_v_r && (rd_key == key_r);

  assign sts.scan_last = (idx_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_data_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_e_t'(in_tuser);
      key_r  <= in_tdata[KEY_LSB +: KEY_W];
      rate_r <= in_tdata[RATE_LSB +: RATE_W];
      fv_r   <= in_tdata[FV_LSB];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rd_data_r <= mem[idx_r];
    end
    if (mem_we) begin
      mem[wr_idx] <= {key_r, rate_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pend_r   <= 1'b0;
      rd_idx_r <= '0;
      rd_v_r   <= 1'b0;
    end else begin
      pend_r <= ctl.read;
      if (ctl.load) begin
        idx_r <= '0;
      end else if (ctl.read) begin
        rd_idx_r <= idx_r;
        rd_v_r   <= valid_r[idx_r];
        if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      match_idx_r   <= '0;
      match_rate_r  <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      any_other_r   <= 1'b0;
      max_other_r   <= '0;
    end else if (ctl.load) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      any_other_r   <= 1'b0;
      max_other_r   <= '0;
    end else if (pend_r) begin
      if (hit) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
        match_rate_r  <= rd_rate;
      end else if (rd_v_r) begin
        any_other_r <= 1'b1;
        if (rd_rate > max_other_r) begin
          max_other_r <= rd_rate;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  always_comb begin
    mem_we      = 1'b0;
    wr_idx      = free_idx_r;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    anim_nxt    = anim_r;
    sync_nxt    = sync_r;
    flag_nxt    = flag_r;
    status_nxt  = STS_NOEFFECT;
    add_applied = 1'b0;
    upd_applied = 1'b0;
    unique case (cmd_r)
      CMD_ADD: begin
        if (!match_found_r) begin
          if (!free_found_r) begin
            status_nxt = STS_FULL;
          end else begin
            add_applied = 1'b1;
            mem_we      = 1'b1;
            set_valid   = 1'b1;
            flag_nxt    = 1'b1;
            status_nxt  = STS_APPLIED;
          end
        end
      end
      CMD_REMOVE: begin
        if (match_found_r) begin
          wr_idx     = match_idx_r;
          clr_valid  = 1'b1;
          flag_nxt   = 1'b1;
          status_nxt = STS_APPLIED;
        end
      end
      CMD_UPDATE: begin
        if (match_found_r && (match_rate_r != rate_r)) begin
          upd_applied = 1'b1;
          wr_idx      = match_idx_r;
          mem_we      = 1'b1;
          flag_nxt    = 1'b1;
          status_nxt  = STS_APPLIED;
        end
      end
      CMD_SET_ANIM: begin
        if (anim_r != rate_r) begin
          anim_nxt   = rate_r;
          flag_nxt   = 1'b1;
          status_nxt = STS_APPLIED;
        end
      end
      CMD_SET_SYNC: begin
        if (sync_r != rate_r) begin
          sync_nxt   = rate_r;
          flag_nxt   = 1'b1;
          status_nxt = STS_APPLIED;
        end
      end
      CMD_WRITE_FLG: begin
        flag_nxt = fv_r;
        if (flag_r != fv_r) begin
          status_nxt = STS_APPLIED;
        end
      end
      default: begin
      end
    endcase
    mem_we = mem_we && ctl.commit;
  end

  // table maximum after the command, then sync and animation overrides when strictly larger
  always_comb begin
    keep_match = match_found_r && (cmd_r != CMD_REMOVE);
    match_val  = upd_applied ? rate_r : match_rate_r;
    t_any      = any_other_r;
    best       = max_other_r;
    if (keep_match) begin
      t_any = 1'b1;
      if (match_val > best) begin
        best = match_val;
      end
    end
    if (add_applied) begin
      t_any = 1'b1;
      if (rate_r > best) begin
        best = rate_r;
      end
    end
    src = t_any ? SRC_TABLE : SRC_NONE;
    if (sync_nxt > best) begin
      best = sync_nxt;
      src  = SRC_SYNC;
    end
    if (anim_nxt > best) begin
      best = anim_nxt;
      src  = SRC_ANIM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      anim_r      <= '0;
      sync_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        if (set_valid) begin
          valid_r[wr_idx] <= 1'b1;
        end
        if (clr_valid) begin
          valid_r[wr_idx] <= 1'b0;
        end
        anim_r      <= anim_nxt;
        sync_r      <= sync_nxt;
        flag_r      <= flag_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data_r <= {status_nxt, sync_nxt, flag_nxt, src, best};
    end
  end

`ifndef SYNTH
  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("result beat not loaded after commit");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit && match_found_r && !ctl.load))
    else $error("node id matched in two slots");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && status_nxt == STS_FULL) |-> ($countones(valid_r) == TABLE_ENTRIES))
    else $error("table full reported with a free slot");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> sts.out_free)
    else $error("commit while result register busy");
`endif

endmodule
